/* rtl/dvrt_pkg.sv */
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants for the distance-vector route table.
// ----------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned MAX_HOPS_DEF    = 3;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned COST_W   = 8;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [COST_W-1:0] COST_MAX      = '1;
  localparam logic [COST_W-1:0] COST_NEIGHBOR = COST_W'(1);
  localparam logic [COST_W-1:0] COST_SELF     = '0;

  typedef enum logic [OP_W-1:0] {
    OP_ADVERT   = 2'd0,
    OP_NEIGHBOR = 2'd1,
    OP_SELF     = 2'd2,
    OP_LOOKUP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW        = 3'd0,
    ST_REPLACED   = 3'd1,
    ST_IGNORED    = 3'd2,
    ST_HOP_ADDED  = 3'd3,
    ST_HOPS_FULL  = 3'd4,
    ST_DUPLICATE  = 3'd5,
    ST_TABLE_FULL = 3'd6,
    ST_LOOKUP     = 3'd7
  } status_e;

endpackage

`default_nettype wire

/* rtl/dvrt_if.sv */
// ----------------------------------------------------------------------------
// dvrt_if
// Valid/ready channels of the route table: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvrt_in_if;
  logic                          valid;
  logic                          ready;
  logic [dvrt_pkg::OP_W-1:0]     op;
  logic [dvrt_pkg::ADDR_W-1:0]   dest;
  logic [dvrt_pkg::COST_W-1:0]   adv_cost;
  logic [dvrt_pkg::ADDR_W-1:0]   sender;

  modport source (output valid, op, dest, adv_cost, sender, input ready);
  modport sink   (input valid, op, dest, adv_cost, sender, output ready);
endinterface

interface dvrt_out_if;
  logic                          valid;
  logic                          ready;
  logic [dvrt_pkg::STATUS_W-1:0] status;
  logic                          found;
  logic [dvrt_pkg::ADDR_W-1:0]   next_hop;
  logic [dvrt_pkg::COST_W-1:0]   best_cost;

  modport source (output valid, status, found, next_hop, best_cost, input ready);
  modport sink   (input valid, status, found, next_hop, best_cost, output ready);
endinterface

`default_nettype wire

/* rtl/dvrt_ram.sv */
// ----------------------------------------------------------------------------
// dvrt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/distance_vector_route_table.sv */
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Distance-vector route table with equal-cost multipath next hops.
// ----------------------------------------------------------------------------
//
//  channel   dir  interface    payload
//  --------  ---  -----------  ------------------------------------------
//  in_i      in   dvrt_in_if   op, dest, adv_cost, sender
//  out_o     out  dvrt_out_if  status, found, next_hop, best_cost
//  cfg       in   we + data    local router address (single register)
//
//  A request passes through an accept step, a scan of the filled part of the
//  entry RAM at one read per cycle (then the registered read drains and the
//  match is latched), a walk over the stored next hops of a matching entry,
//  and a decide/write-back step. The single RAM read port paces the scan.
//  in_i.ready is high only while idle.
//  Reset clears the fill count but not the RAM; entries are always packed
//  from slot 0, so no clearing pass over the RAM is needed. A result waits
//  in the output register; a new request is taken meanwhile and stalls at
//  write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_table #(
  parameter int unsigned TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_HOPS    = dvrt_pkg::MAX_HOPS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dvrt_pkg::ADDR_W-1:0] cfg_wdata_i,
  dvrt_in_if.sink                          in_i,
  dvrt_out_if.source                       out_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);     // fill / scan counter
  localparam int unsigned HC_W = $clog2(MAX_HOPS + 1);        // hop count
  localparam int unsigned KW   = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int unsigned A_W  = dvrt_pkg::ADDR_W;
  localparam int unsigned C_W  = dvrt_pkg::COST_W;

  // Entry word: {hops[MAX_HOPS-1..0], hop_count, cost, dest}
  localparam int unsigned COST_LSB = A_W;
  localparam int unsigned CNT_LSB  = A_W + C_W;
  localparam int unsigned HOP_LSB  = CNT_LSB + HC_W;
  localparam int unsigned ENT_W    = HOP_LSB + A_W * MAX_HOPS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOP,
    S_DECIDE
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           fill_q, fill_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    pend_q, pend_d;
  logic [AW-1:0]           pend_addr_q, pend_addr_d;
  logic                    hit_q, hit_d;
  logic [AW-1:0]           slot_q, slot_d;
  logic [ENT_W-1:0]        ent_q, ent_d;
  logic [HC_W-1:0]         k_q, k_d;
  logic                    dup_q, dup_d;
  logic [A_W-1:0]          min_q, min_d;
  dvrt_pkg::op_e           op_q, op_d;
  logic [A_W-1:0]          key_q, key_d;
  logic [C_W-1:0]          cost_q, cost_d;
  logic [A_W-1:0]          hop_q, hop_d;
  logic [A_W-1:0]          my_addr_q, my_addr_d;

  logic                    out_valid_q, out_valid_d;
  dvrt_pkg::status_e       out_status_q, out_status_d;
  logic                    out_found_q, out_found_d;
  logic [A_W-1:0]          out_nh_q, out_nh_d;
  logic [C_W-1:0]          out_cost_q, out_cost_d;

  // RAM port signals
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ENT_W-1:0]        ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [ENT_W-1:0]        ram_rdata;

  // Stored entry fields
  logic [C_W-1:0]          ent_cost;
  logic [HC_W-1:0]         ent_cnt;
  logic [A_W-1:0]          ent_hops [MAX_HOPS];
  logic [A_W*MAX_HOPS-1:0] hops_one;
  logic [A_W*MAX_HOPS-1:0] hops_add;
  logic [A_W-1:0]          cur_hop;

  logic                    in_xfer;
  logic                    out_free;

  // Decide-stage results before commit
  logic                    dec_we;
  logic [AW-1:0]           dec_waddr;
  logic [ENT_W-1:0]        dec_wdata;
  logic                    dec_grow;
  dvrt_pkg::status_e       dec_status;
  logic                    dec_found;
  logic [A_W-1:0]          dec_nh;
  logic [C_W-1:0]          dec_cost;

  dvrt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready      = (state_q == S_IDLE);
  assign in_xfer         = in_i.valid && in_i.ready;
  assign out_free        = !out_valid_q || out_o.ready;

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.found     = out_found_q;
  assign out_o.next_hop  = out_nh_q;
  assign out_o.best_cost = out_cost_q;

  assign ent_cost = ent_q[COST_LSB +: C_W];
  assign ent_cnt  = ent_q[CNT_LSB +: HC_W];

  // Unpack the captured entry's hops and build the two hop-list updates:
  // a fresh one-hop list, and the list with hop_q appended at ent_cnt.
  always_comb begin
    for (int k = 0; k < MAX_HOPS; k++) begin
      ent_hops[k]         = ent_q[HOP_LSB + A_W*k +: A_W];
      hops_one[A_W*k +: A_W] = (k == 0) ? hop_q : '0;
      hops_add[A_W*k +: A_W] = (ent_cnt == HC_W'(k)) ? hop_q : ent_hops[k];
    end
  end

  // Shared hop compare unit input
  assign cur_hop = ent_hops[k_q[KW-1:0]];

  // Offer resolution and lookup result, evaluated in the decide state
  always_comb begin
    dec_we     = 1'b0;
    dec_waddr  = slot_q;
    dec_wdata  = ent_q;
    dec_grow   = 1'b0;
    dec_status = dvrt_pkg::ST_LOOKUP;
    dec_found  = 1'b0;
    dec_nh     = '0;
    dec_cost   = '0;
    if (op_q == dvrt_pkg::OP_LOOKUP) begin
      if (hit_q && (ent_cnt != '0)) begin
        dec_found = 1'b1;
        dec_nh    = min_q;
        dec_cost  = ent_cost;
      end
    end else if (!hit_q) begin
      if (fill_q == CW'(TABLE_DEPTH)) begin
        dec_status = dvrt_pkg::ST_TABLE_FULL;
      end else begin
        dec_we     = 1'b1;
        dec_waddr  = fill_q[AW-1:0];
        dec_wdata  = {hops_one, HC_W'(1), cost_q, key_q};
        dec_grow   = 1'b1;
        dec_status = dvrt_pkg::ST_NEW;
        dec_cost   = cost_q;
      end
    end else if (cost_q < ent_cost) begin
      dec_we     = 1'b1;
      dec_wdata  = {hops_one, HC_W'(1), cost_q, key_q};
      dec_status = dvrt_pkg::ST_REPLACED;
      dec_cost   = cost_q;
    end else begin
      dec_cost = ent_cost;
      if (cost_q != ent_cost) begin
        dec_status = dvrt_pkg::ST_IGNORED;
      end else if (ent_cnt >= HC_W'(MAX_HOPS)) begin
        // set full wins over duplicate
        dec_status = dvrt_pkg::ST_HOPS_FULL;
      end else if (dup_q) begin
        dec_status = dvrt_pkg::ST_DUPLICATE;
      end else begin
        dec_we     = 1'b1;
        dec_wdata  = {hops_add, ent_cnt + HC_W'(1), ent_cost, key_q};
        dec_status = dvrt_pkg::ST_HOP_ADDED;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    hit_d        = hit_q;
    slot_d       = slot_q;
    ent_d        = ent_q;
    k_d          = k_q;
    dup_d        = dup_q;
    min_d        = min_q;
    op_d         = op_q;
    key_d        = key_q;
    cost_d       = cost_q;
    hop_d        = hop_q;
    my_addr_d    = cfg_we_i ? cfg_wdata_i : my_addr_q;
    out_valid_d  = (out_valid_q && out_o.ready) ? 1'b0 : out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_nh_d     = out_nh_q;
    out_cost_d   = out_cost_q;
    ram_we       = 1'b0;
    ram_waddr    = dec_waddr;
    ram_wdata    = dec_wdata;
    ram_re       = 1'b0;
    ram_raddr    = cnt_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d  = dvrt_pkg::op_e'(in_i.op);
          key_d = in_i.dest;
          case (dvrt_pkg::op_e'(in_i.op))
            dvrt_pkg::OP_ADVERT: begin
              cost_d = (in_i.adv_cost == dvrt_pkg::COST_MAX) ?
                       dvrt_pkg::COST_MAX : in_i.adv_cost + C_W'(1);
              hop_d  = in_i.sender;
            end
            dvrt_pkg::OP_NEIGHBOR: begin
              cost_d = dvrt_pkg::COST_NEIGHBOR;
              hop_d  = in_i.dest;
            end
            dvrt_pkg::OP_SELF: begin
              key_d  = my_addr_q;
              cost_d = dvrt_pkg::COST_SELF;
              hop_d  = '0;
            end
            default: begin
              cost_d = '0;
              hop_d  = '0;
            end
          endcase
          cnt_d   = '0;
          pend_d  = 1'b0;
          hit_d   = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // one read issued per cycle; compare the word read last cycle
        ram_re      = (cnt_q < fill_q);
        pend_d      = ram_re;
        pend_addr_d = cnt_q[AW-1:0];
        if (ram_re) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (pend_q && (ram_rdata[A_W-1:0] == key_q)) begin
          hit_d  = 1'b1;
          slot_d = pend_addr_q;
          ent_d  = ram_rdata;
        end
        if (!ram_re && !pend_q) begin
          k_d     = '0;
          dup_d   = 1'b0;
          min_d   = ent_hops[0];
          state_d = hit_q ? S_HOP : S_DECIDE;
        end
      end

      S_HOP: begin
        // one stored hop per cycle: duplicate check and running minimum
        if (cur_hop == hop_q) begin
          dup_d = 1'b1;
        end
        if (cur_hop < min_q) begin
          min_d = cur_hop;
        end
        k_d = k_q + HC_W'(1);
        if ((k_q + HC_W'(1)) >= ent_cnt) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        // commit only when the output register can take the result
        if (out_free) begin
          ram_we       = dec_we;
          if (dec_grow) begin
            fill_d = fill_q + CW'(1);
          end
          out_valid_d  = 1'b1;
          out_status_d = dec_status;
          out_found_d  = dec_found;
          out_nh_d     = dec_nh;
          out_cost_d   = dec_cost;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      hit_q        <= 1'b0;
      slot_q       <= '0;
      ent_q        <= '0;
      k_q          <= '0;
      dup_q        <= 1'b0;
      min_q        <= '0;
      op_q         <= dvrt_pkg::OP_ADVERT;
      key_q        <= '0;
      cost_q       <= '0;
      hop_q        <= '0;
      my_addr_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= dvrt_pkg::ST_NEW;
      out_found_q  <= 1'b0;
      out_nh_q     <= '0;
      out_cost_q   <= '0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
      pend_addr_q  <= pend_addr_d;
      hit_q        <= hit_d;
      slot_q       <= slot_d;
      ent_q        <= ent_d;
      k_q          <= k_d;
      dup_q        <= dup_d;
      min_q        <= min_d;
      op_q         <= op_d;
      key_q        <= key_d;
      cost_q       <= cost_d;
      hop_q        <= hop_d;
      my_addr_q    <= my_addr_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_nh_q     <= out_nh_d;
      out_cost_q   <= out_cost_d;
    end
  end

  // Assertions

  // fill count only ever grows by one entry at a time
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == ($past(fill_q) + CW'(1))))
    else $error("fill count jumped");

  // writes stay inside the packed region (existing slot or next free slot)
  a_write_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) <= fill_q) && (fill_q <= CW'(TABLE_DEPTH)))
    else $error("RAM write outside filled region");

  // a new result appears only out of the decide step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DECIDE))
    else $error("result without decide step");

  // an accepted request always starts a scan
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_SCAN))
    else $error("accepted request did not start scan");

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the distance-vector route table. A scoreboard model
// of the table predicts status, found, next hop and best cost for every
// request transfer; a monitor compares each result transfer against the
// oldest prediction. Directed cases cover the merge rules, cost saturation,
// neighbor and self installs and lookups. Random traffic then runs over a
// small address pool, under back-pressure and back to back, and finally
// against a full table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned DEPTH      = dvrt_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned HOPS       = dvrt_pkg::MAX_HOPS_DEF;
  localparam int unsigned A_W        = dvrt_pkg::ADDR_W;
  localparam int unsigned C_W        = dvrt_pkg::COST_W;
  localparam int unsigned POOL_DESTS = 12;
  localparam int unsigned POOL_SNDRS = 6;
  localparam int unsigned HOLD_CYCLES = 300;
  // Worst case per transfer is a full table scan plus a long sender gap
  // and a long receiver stall; this is several times the slowest clean run.
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    dvrt_pkg::status_e   status;
    logic                found;
    logic [A_W-1:0]      next_hop;
    logic [C_W-1:0]      best_cost;
  } route_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [A_W-1:0] cfg_wdata_i;

  dvrt_in_if  req_if ();
  dvrt_out_if rsp_if ();

  distance_vector_route_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  // --------------------------------------------------------------------------
  // Clock, period 8.
  // --------------------------------------------------------------------------
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // --------------------------------------------------------------------------
  // Route table model. Updated at the edge where a request transfer happens,
  // so it always mirrors what the block has committed to.
  // --------------------------------------------------------------------------
  logic              rt_used [DEPTH];
  logic [A_W-1:0]    rt_dest [DEPTH];
  logic [C_W-1:0]    rt_cost [DEPTH];
  int unsigned       rt_nhops[DEPTH];
  logic [A_W-1:0]    rt_hop  [DEPTH][HOPS];
  logic [A_W-1:0]    my_addr_model;

  route_result_t expected_routes[$];
  int unsigned   errors;
  bit            gaps_on;
  bit            hold_request;

  logic [A_W-1:0] dest_pool  [POOL_DESTS];
  logic [A_W-1:0] sender_pool[POOL_SNDRS];

  function automatic int find_route(input logic [A_W-1:0] d);
    for (int i = 0; i < DEPTH; i++)
      if (rt_used[i] && rt_dest[i] == d) return i;
    return -1;
  endfunction

  function automatic int table_fill();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++)
      if (rt_used[i]) n++;
    return n;
  endfunction

  // One offer of (dest, cost, hop): add, replace, merge or ignore.
  function automatic dvrt_pkg::status_e merge_offer(input logic [A_W-1:0] d,
                                                    input logic [C_W-1:0] c,
                                                    input logic [A_W-1:0] hop,
                                                    output logic [C_W-1:0] cost_after);
    int s;
    s = find_route(d);
    cost_after = '0;
    if (s < 0) begin
      // lowest free slot, or nothing changes
      for (int i = 0; i < DEPTH; i++)
        if (!rt_used[i] && s < 0) s = i;
      if (s < 0) return dvrt_pkg::ST_TABLE_FULL;
      rt_used[s]   = 1'b1;
      rt_dest[s]   = d;
      rt_cost[s]   = c;
      rt_nhops[s]  = 1;
      rt_hop[s][0] = hop;
      cost_after   = c;
      return dvrt_pkg::ST_NEW;
    end
    if (c < rt_cost[s]) begin
      rt_cost[s]   = c;
      rt_nhops[s]  = 1;
      rt_hop[s][0] = hop;
      cost_after   = c;
      return dvrt_pkg::ST_REPLACED;
    end
    cost_after = rt_cost[s];
    if (c > rt_cost[s]) return dvrt_pkg::ST_IGNORED;
    // full set wins over duplicate
    if (rt_nhops[s] >= HOPS) return dvrt_pkg::ST_HOPS_FULL;
    for (int k = 0; k < rt_nhops[s]; k++)
      if (rt_hop[s][k] == hop) return dvrt_pkg::ST_DUPLICATE;
    rt_hop[s][rt_nhops[s]] = hop;
    rt_nhops[s]++;
    return dvrt_pkg::ST_HOP_ADDED;
  endfunction

  function automatic route_result_t route_update(input dvrt_pkg::op_e op,
                                                 input logic [A_W-1:0] d,
                                                 input logic [C_W-1:0] ac,
                                                 input logic [A_W-1:0] snd);
    route_result_t r;
    logic [C_W-1:0] c;
    int s;
    r = '0;
    case (op)
      dvrt_pkg::OP_ADVERT: begin
        c = (ac == dvrt_pkg::COST_MAX) ? dvrt_pkg::COST_MAX : ac + C_W'(1);
        r.status = merge_offer(d, c, snd, r.best_cost);
      end
      dvrt_pkg::OP_NEIGHBOR: begin
        r.status = merge_offer(d, dvrt_pkg::COST_NEIGHBOR, d, r.best_cost);
      end
      dvrt_pkg::OP_SELF: begin
        r.status = merge_offer(my_addr_model, dvrt_pkg::COST_SELF, '0, r.best_cost);
      end
      default: begin
        r.status = dvrt_pkg::ST_LOOKUP;
        s = find_route(d);
        if (s >= 0 && rt_nhops[s] > 0) begin
          r.found    = 1'b1;
          r.next_hop = rt_hop[s][0];
          for (int k = 1; k < rt_nhops[s]; k++)
            if (rt_hop[s][k] < r.next_hop) r.next_hop = rt_hop[s][k];
          r.best_cost = rt_cost[s];
        end
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor: every result transfer is checked against the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    route_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_routes.size() == 0) begin
        $display("%0t: result expected none actual status %0d found %0d hop %h cost %0d",
                 $time, rsp_if.status, rsp_if.found, rsp_if.next_hop,
                 rsp_if.best_cost);
        errors++;
      end else begin
        want = expected_routes.pop_front();
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   rsp_if.status);
          errors++;
        end
        if (rsp_if.found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found,
                   rsp_if.found);
          errors++;
        end
        if (rsp_if.next_hop !== want.next_hop) begin
          $display("%0t: next_hop expected %h actual %h", $time, want.next_hop,
                   rsp_if.next_hop);
          errors++;
        end
        if (rsp_if.best_cost !== want.best_cost) begin
          $display("%0t: best_cost expected %0d actual %0d", $time,
                   want.best_cost, rsp_if.best_cost);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result ready. Random stalls, mostly short, a few long; a hold request
  // from a test turns into one long stretch counted here.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 99) < 30) begin
        rsp_if.ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                 : $urandom_range(0, 3);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("distance_vector_route_table verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request side. valid stays up across back-to-back transfers and is only
  // dropped for a gap or before the bench waits for something else.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input dvrt_pkg::op_e op, input logic [A_W-1:0] d,
                              input logic [C_W-1:0] ac,
                              input logic [A_W-1:0] snd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.dest     <= d;
    req_if.adv_cost <= ac;
    req_if.sender   <= snd;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    // transfer at this edge
    expected_routes.push_back(route_update(op, d, ac, snd));
  endtask

  // Block is idle once every predicted result has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_routes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_local_addr(input logic [A_W-1:0] addr);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    my_addr_model = addr;
    cfg_we_i    <= 1'b0;
  endtask

  function automatic dvrt_pkg::op_e pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return dvrt_pkg::OP_ADVERT;
    if (r < 75) return dvrt_pkg::OP_LOOKUP;
    if (r < 90) return dvrt_pkg::OP_NEIGHBOR;
    return dvrt_pkg::OP_SELF;
  endfunction

  // Mostly pool addresses and small costs so that equal-cost merges, full
  // hop sets and replacements happen often; noise_pct is fully random.
  task automatic send_random_item(input int noise_pct);
    logic [A_W-1:0] d, snd;
    logic [C_W-1:0] ac;
    if ($urandom_range(0, 99) < noise_pct) begin
      send_request(dvrt_pkg::op_e'($urandom_range(0, 3)), A_W'($urandom),
                   C_W'($urandom), A_W'($urandom));
    end else begin
      d   = dest_pool[$urandom_range(0, POOL_DESTS - 1)];
      snd = ($urandom_range(0, 3) == 0) ? dest_pool[$urandom_range(0, POOL_DESTS - 1)]
                                        : sender_pool[$urandom_range(0, POOL_SNDRS - 1)];
      ac  = ($urandom_range(0, 9) < 7) ? C_W'($urandom_range(0, 4))
                                       : C_W'($urandom_range(0, 255));
      send_request(pick_op(), d, ac, snd);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_empty_lookup();
    send_request(dvrt_pkg::OP_LOOKUP, 16'h0000, 8'h00, 16'h0000);
    send_request(dvrt_pkg::OP_LOOKUP, 16'hFFFF, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_advert_merge();
    send_request(dvrt_pkg::OP_ADVERT, 16'h1234, 8'd5, 16'h0010);   // new at 6
    send_request(dvrt_pkg::OP_ADVERT, 16'h1234, 8'd5, 16'h0020);   // second hop
    send_request(dvrt_pkg::OP_ADVERT, 16'h1234, 8'd5, 16'h0010);   // already a hop
    send_request(dvrt_pkg::OP_ADVERT, 16'h1234, 8'd5, 16'hFFFF);   // third hop
    send_request(dvrt_pkg::OP_ADVERT, 16'h1234, 8'd5, 16'h0000);   // set full
    send_request(dvrt_pkg::OP_ADVERT, 16'h1234, 8'd5, 16'h0010);   // full beats duplicate
    send_request(dvrt_pkg::OP_LOOKUP, 16'h1234, 8'd0, 16'h0000);
    send_request(dvrt_pkg::OP_ADVERT, 16'h1234, 8'd9, 16'h0030);   // dearer
    send_request(dvrt_pkg::OP_ADVERT, 16'h1234, 8'd2, 16'h0040);   // cheaper
    send_request(dvrt_pkg::OP_LOOKUP, 16'h1234, 8'd0, 16'h0000);
    send_request(dvrt_pkg::OP_ADVERT, 16'hFFFF, 8'd255, 16'h0001); // saturates at 255
    send_request(dvrt_pkg::OP_ADVERT, 16'hFFFF, 8'd254, 16'h0002); // also 255
    send_request(dvrt_pkg::OP_ADVERT, 16'h0000, 8'd0, 16'hFFFF);
  endtask

  task automatic test_neighbor();
    send_request(dvrt_pkg::OP_NEIGHBOR, 16'h00A5, 8'd0, 16'h0000);
    send_request(dvrt_pkg::OP_NEIGHBOR, 16'h00A5, 8'hFF, 16'hFFFF);
    send_request(dvrt_pkg::OP_ADVERT, 16'h00A5, 8'd0, 16'h0003);
    send_request(dvrt_pkg::OP_LOOKUP, 16'h00A5, 8'd0, 16'h0000);
    send_request(dvrt_pkg::OP_NEIGHBOR, 16'h0000, 8'd0, 16'h0000);
  endtask

  task automatic test_self_install();
    write_local_addr(16'h0000);
    send_request(dvrt_pkg::OP_SELF, 16'h5A5A, 8'd7, 16'h1111);    // replaces dest 0
    send_request(dvrt_pkg::OP_SELF, 16'h0000, 8'd0, 16'h0000);    // hop 0 again
    write_local_addr(16'hFFFF);
    send_request(dvrt_pkg::OP_SELF, 16'hFFFF, 8'd0, 16'h0000);    // replaces the 255 route
    send_request(dvrt_pkg::OP_LOOKUP, 16'hFFFF, 8'd0, 16'h0000);
  endtask

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < POOL_DESTS; i++) dest_pool[i] = A_W'($urandom);
    for (int i = 0; i < POOL_SNDRS; i++) sender_pool[i] = A_W'($urandom);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 59) begin
        case ((i / 60) % 4)
          0: write_local_addr(dest_pool[$urandom_range(0, POOL_DESTS - 1)]);
          1: write_local_addr(A_W'($urandom));
          2: write_local_addr(16'h0000);
          default: write_local_addr(16'hFFFF);
        endcase
      end
      send_random_item(8);
    end
  endtask

  // Receiver holds off while requests keep coming: the block fills and
  // drops its request ready.
  task automatic test_output_stall();
    drain_results();
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) send_random_item(0);
  endtask

  task automatic test_back_to_back(input int n);
    gaps_on = 1'b0;
    for (int i = 0; i < n; i++) send_random_item(5);
    gaps_on = 1'b1;
  endtask

  task automatic test_table_full(input int n);
    while (table_fill() < DEPTH)
      send_request(dvrt_pkg::OP_ADVERT, A_W'($urandom), C_W'($urandom_range(0, 255)),
                   A_W'($urandom));
    for (int i = 0; i < n; i++) send_random_item(40);
    write_local_addr(A_W'($urandom));
    send_request(dvrt_pkg::OP_SELF, 16'h0000, 8'd0, 16'h0000);   // new self, no room
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    errors        = 0;
    gaps_on       = 1'b1;
    hold_request  = 1'b0;
    my_addr_model = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rt_used[i]  = 1'b0;
      rt_dest[i]  = '0;
      rt_cost[i]  = '0;
      rt_nhops[i] = 0;
      for (int k = 0; k < HOPS; k++) rt_hop[i][k] = '0;
    end
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    req_if.valid    <= 1'b0;
    req_if.op       <= dvrt_pkg::OP_ADVERT;
    req_if.dest     <= '0;
    req_if.adv_cost <= '0;
    req_if.sender   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lookup();
    test_advert_merge();
    test_neighbor();
    test_self_install();
    test_random_traffic(420);
    test_output_stall();
    test_back_to_back(60);
    test_table_full(110);

    drain_results();
    repeat (80) @(posedge clk_i);
    if (expected_routes.size() != 0) errors++;
    if (errors == 0)
      $display("distance_vector_route_table verification clean");
    else
      $display("distance_vector_route_table verification failed");
    $finish;
  end

endmodule

`default_nettype wire
